[sv/salsf_pkg.sv]
// Shared constants, types and operation codes for the seen-before filter.
`default_nettype none

package salsf_pkg;

	// Table geometry
	localparam int NUM_SETS = 256;
	localparam int NUM_WAYS = 4;
	localparam int SET_W    = $clog2(NUM_SETS);
	localparam int POS_W    = $clog2(NUM_WAYS);

	// Field widths
	localparam int ID_W   = 64;
	localparam int HASH_W = 32;
	localparam int WAY_W  = 3;

	// Position code reported for miss, clear or zero identifier
	localparam logic [WAY_W-1:0] NO_HIT = WAY_W'(4);

	// Operation codes
	typedef enum logic {
		FUNC_LOOKUP = 1'b0,
		FUNC_CLEAR  = 1'b1
	} func_t;

	// One set: position 0 is the most recently used entry
	typedef logic [NUM_WAYS-1:0][ID_W-1:0] row_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;   // capture item and read its set
		logic look;   // compare, update set, issue result
	} cmd_t;

endpackage : salsf_pkg

`default_nettype wire

[sv/salsf_ctrl.sv]
// Controller state machine: sequences one item through read and update.
`default_nettype none

module salsf_ctrl
	import salsf_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	output cmd_t      cmd
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_LOOK = 2'b10
	} state_t;

	state_t state_q;
	state_t state_nxt;

	// Next-state logic
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start)
					state_nxt = S_LOOK;
			end
			S_LOOK: begin
				state_nxt = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_nxt;
	end

	// Commands and status
	assign busy     = (state_q != S_IDLE);
	assign cmd.load = (state_q == S_IDLE) && start;
	assign cmd.look = (state_q == S_LOOK);

endmodule : salsf_ctrl

`default_nettype wire

[sv/salsf_dp.sv]
// Datapath: set memory, row valid bits, way compare, recency update, result register.
`default_nettype none

module salsf_dp
	import salsf_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cmd_t              cmd,
	input  wire logic              func,
	input  wire logic [ID_W-1:0]   type_id,
	input  wire logic [HASH_W-1:0] type_hash,
	output logic                   done,
	output logic                   emit_needed,
	output logic [WAY_W-1:0]       hit_way
);

	// Set memory and one valid bit per set (invalid set reads as empty)
	row_t                mem [NUM_SETS];
	logic [NUM_SETS-1:0] row_vld_q;

	// Captured item
	logic             func_q;
	logic [ID_W-1:0]  id_q;
	logic [SET_W-1:0] set_q;
	row_t             rd_row_q;
	logic             rd_vld_q;

	// Lookup logic
	row_t             row;
	row_t             new_row;
	logic             hit;
	logic [POS_W-1:0] hit_pos;
	logic             is_clear;
	logic             id_zero;
	logic             wr_en;

	// Result registers
	logic             done_q;
	logic             emit_q;
	logic [WAY_W-1:0] hit_way_q;

	// Item capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			id_q   <= type_id;
			set_q  <= type_hash[SET_W-1:0];
		end
	end

	// Memory: registered read at capture, write on update
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[set_q] <= new_row;
		if (cmd.load)
			rd_row_q <= mem[type_hash[SET_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rd_vld_q <= 1'b0;
		else if (cmd.load)
			rd_vld_q <= row_vld_q[type_hash[SET_W-1:0]];
	end

	// Valid bits: clear drops them all at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			row_vld_q <= '0;
		else if (cmd.look && is_clear)
			row_vld_q <= '0;
		else if (wr_en)
			row_vld_q[set_q] <= 1'b1;
	end

	assign row      = rd_vld_q ? rd_row_q : '0;
	assign is_clear = (func_q == FUNC_CLEAR);
	assign id_zero  = (id_q == '0);
	assign wr_en    = cmd.look && !is_clear && !id_zero;

	// Way compare: first matching position wins
	always_comb begin
		hit     = 1'b0;
		hit_pos = '0;
		for (int w = NUM_WAYS - 1; w >= 0; w--) begin
			if (row[w] == id_q) begin
				hit     = 1'b1;
				hit_pos = POS_W'(w);
			end
		end
	end

	// Recency update: entries ahead of the hit (all on a miss) move back one
	always_comb begin
		new_row    = row;
		new_row[0] = id_q;
		for (int k = 1; k < NUM_WAYS; k++) begin
			if (!hit || (k <= int'(hit_pos)))
				new_row[k] = row[k-1];
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= cmd.look;
	end

	always_ff @(posedge clk) begin
		if (cmd.look) begin
			emit_q    <= !is_clear && !id_zero && !hit;
			hit_way_q <= (!is_clear && !id_zero && hit) ? WAY_W'(hit_pos) : NO_HIT;
		end
	end

	assign done        = done_q;
	assign emit_needed = done_q && emit_q;
	assign hit_way     = hit_way_q;

endmodule : salsf_dp

`default_nettype wire

[sv/set_assoc_lru_seen_filter.sv]
// Top level of the set-associative LRU seen-before filter.
//
//  channel   handshake       fields                          direction
//  command   start / busy    func, type_id, type_hash        in
//  result    done (strobe)   emit_needed, hit_way            out
//
// Each transfer first reads the set from memory, then compares the ways, writes the
// updated set back and registers the result.
// Result appears the cycle after update; a new command is taken in that same cycle.
// Reset clears the per-set valid bits, so the table reads empty at once; clear does the same.
// The result strobe lasts one cycle; the receiver cannot stall it.
`default_nettype none

module set_assoc_lru_seen_filter
	import salsf_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic              func,
	input  wire logic [ID_W-1:0]   type_id,
	input  wire logic [HASH_W-1:0] type_hash,
	output logic                   done,
	output logic                   emit_needed,
	output logic [WAY_W-1:0]       hit_way
);

	cmd_t cmd;

	salsf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	salsf_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.func        (func),
		.type_id     (type_id),
		.type_hash   (type_hash),
		.done        (done),
		.emit_needed (emit_needed),
		.hit_way     (hit_way)
	);

`ifndef NO_ASSERTIONS
	// An accepted command is in work on the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted command did not raise busy");

	// Work always ends in a result on the next cycle
	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> (done && !busy))
		else $error("update cycle not followed by result");

	// Result strobe only when idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// Emission only on a miss
	a_emit_miss: assert property (@(posedge clk) disable iff (!arst_n)
		emit_needed |-> (done && (hit_way == NO_HIT)))
		else $error("emission flagged without a miss result");
`endif

endmodule : set_assoc_lru_seen_filter

`default_nettype wire

[bench/set_assoc_lru_seen_filter_test.sv]
// Self-checking testbench for the set-associative LRU seen-before filter.
`timescale 1ns / 1ps

module set_assoc_lru_seen_filter_test;
	import salsf_pkg::*;

	localparam real CLK_PERIOD     = 12.0;
	localparam int  RESET_CYCLES   = 10;
	localparam int  RANDOM_ITEMS   = 1600;
	localparam int  NUM_PHASES     = 4;
	localparam int  PHASE_IDLE [NUM_PHASES] = '{0, 59, 0, 13};
	localparam int  PRESSURE_PHASE = 1;
	localparam int  ID_POOL_SIZE   = 8;
	localparam int  DRAIN_CYCLES   = 10;
	localparam int  WATCHDOG_LIMIT = 1000;
	localparam int  MAX_REPORTS    = 10;

	localparam logic [ID_W-1:0]   ID_ONES   = '1;
	localparam logic [ID_W-1:0]   ID_TOP    = {1'b1, {(ID_W-1){1'b0}}};
	localparam logic [HASH_W-1:0] HASH_ONES = '1;
	localparam logic [HASH_W-1:0] HASH_TOP  = {1'b1, {(HASH_W-1){1'b0}}};

	// One expected result
	typedef struct packed {
		logic             emit;
		logic [WAY_W-1:0] way;
	} verdict_t;

	// One directed command; the verdict is used only where pinned is set
	typedef struct {
		func_t             op;
		logic [ID_W-1:0]   id;
		logic [HASH_W-1:0] hash;
		logic              pinned;
		logic              emit;
		logic [WAY_W-1:0]  way;
	} stim_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic              func = FUNC_LOOKUP;
	logic [ID_W-1:0]   type_id = '0;
	logic [HASH_W-1:0] type_hash = '0;
	logic              done;
	logic              emit_needed;
	logic [WAY_W-1:0]  hit_way;

	// Pinned verdict travels alongside the command it belongs to
	logic              pin_valid = 1'b0;
	verdict_t          pin_verdict = '0;

	logic [ID_W-1:0]   seen_rows [NUM_SETS][NUM_WAYS];
	verdict_t          pending_verdicts [$];
	logic [ID_W-1:0]   id_pool [ID_POOL_SIZE];
	int                idle_pct = 0;
	int                failures = 0;
	int                quiet_cycles = 0;

	// Set 0 walks through hits at every position, eviction and re-insertion
	stim_row_t directed_rows [23] = '{
		'{FUNC_LOOKUP, '0,      '0,        1'b1, 1'b0, NO_HIT},
		'{FUNC_LOOKUP, 64'd1,   '0,        1'b1, 1'b1, NO_HIT},
		'{FUNC_LOOKUP, 64'd1,   '0,        1'b1, 1'b0, 3'd0},
		'{FUNC_LOOKUP, ID_ONES, HASH_ONES, 1'b1, 1'b1, NO_HIT},
		'{FUNC_LOOKUP, ID_ONES, 32'h0FF,   1'b1, 1'b0, 3'd0},
		'{FUNC_LOOKUP, 64'd2,   32'h100,   1'b1, 1'b1, NO_HIT},
		'{FUNC_LOOKUP, 64'd3,   '0,        1'b0, 1'b0, NO_HIT},
		'{FUNC_LOOKUP, 64'd4,   '0,        1'b0, 1'b0, NO_HIT},
		'{FUNC_LOOKUP, 64'd1,   '0,        1'b1, 1'b0, 3'd3},
		'{FUNC_LOOKUP, 64'd2,   '0,        1'b1, 1'b0, 3'd3},
		'{FUNC_LOOKUP, 64'd4,   '0,        1'b0, 1'b0, NO_HIT},
		'{FUNC_LOOKUP, 64'd2,   '0,        1'b0, 1'b0, NO_HIT},
		'{FUNC_LOOKUP, 64'd5,   '0,        1'b1, 1'b1, NO_HIT},
		'{FUNC_LOOKUP, 64'd3,   '0,        1'b1, 1'b1, NO_HIT},
		'{FUNC_LOOKUP, 64'd1,   32'hFFFFFF00, 1'b0, 1'b0, NO_HIT},
		'{FUNC_CLEAR,  ID_ONES, HASH_ONES, 1'b1, 1'b0, NO_HIT},
		'{FUNC_LOOKUP, 64'd5,   '0,        1'b1, 1'b1, NO_HIT},
		'{FUNC_LOOKUP, ID_ONES, HASH_ONES, 1'b1, 1'b1, NO_HIT},
		'{FUNC_LOOKUP, ID_TOP,  HASH_TOP,  1'b0, 1'b0, NO_HIT},
		'{FUNC_CLEAR,  '0,      '0,        1'b1, 1'b0, NO_HIT},
		'{FUNC_LOOKUP, '0,      HASH_ONES, 1'b1, 1'b0, NO_HIT},
		'{FUNC_LOOKUP, ID_TOP,  HASH_TOP,  1'b1, 1'b1, NO_HIT},
		'{FUNC_LOOKUP, ID_TOP,  '0,        1'b0, 1'b0, NO_HIT}
	};

	set_assoc_lru_seen_filter DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.func        (func),
		.type_id     (type_id),
		.type_hash   (type_hash),
		.done        (done),
		.emit_needed (emit_needed),
		.hit_way     (hit_way)
	);

	always #(CLK_PERIOD / 2.0) clk = ~clk;

	// Recency-ordered lookup: updates the table copy, returns the verdict
	function automatic verdict_t learn_id(input func_t op, input logic [ID_W-1:0] id,
			input logic [HASH_W-1:0] hash);
		verdict_t         v;
		logic [SET_W-1:0] row;
		int               found;
		v.emit = 1'b0;
		v.way  = NO_HIT;
		if (op == FUNC_CLEAR) begin
			foreach (seen_rows[s, w]) seen_rows[s][w] = '0;
			return v;
		end
		if (id == '0)
			return v;
		row   = hash[SET_W-1:0];
		found = -1;
		for (int w = 0; w < NUM_WAYS; w++)
			if (found < 0 && seen_rows[row][w] == id)
				found = w;
		// hit moves the entries ahead of it back; miss shifts the whole set
		if (found >= 0) begin
			for (int k = found; k > 0; k--)
				seen_rows[row][k] = seen_rows[row][k-1];
			v.way = WAY_W'(found);
		end else begin
			for (int k = NUM_WAYS - 1; k > 0; k--)
				seen_rows[row][k] = seen_rows[row][k-1];
			v.emit = 1'b1;
		end
		seen_rows[row][0] = id;
		return v;
	endfunction

	function automatic void log_failure(input string msg);
		failures++;
		if (failures <= MAX_REPORTS)
			$display("%0t: %s", $realtime, msg);
	endfunction

	// Drive one command after an optional idle gap; returns at its transfer edge
	task automatic issue_item(input func_t op, input logic [ID_W-1:0] id,
			input logic [HASH_W-1:0] hash, input logic pinned, input verdict_t pin);
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start       <= 1'b1;
		func        <= op;
		type_id     <= id;
		type_hash   <= hash;
		pin_valid   <= pinned;
		pin_verdict <= pin;
		do @(posedge clk); while (busy);
	endtask

	// Result checking, prediction on command transfer, and watchdog
	always @(posedge clk) begin : result_check
		verdict_t want;
		logic     moved;
		if (arst_n) begin
			moved = done || (start && !busy);
			if (done) begin
				if (pending_verdicts.size() == 0) begin
					log_failure($sformatf("result with none pending: emit_needed=%0b hit_way=%0d",
						emit_needed, hit_way));
				end else begin
					want = pending_verdicts.pop_front();
					if (emit_needed !== want.emit)
						log_failure($sformatf("emit_needed: expected %0b, got %0b",
							want.emit, emit_needed));
					if (hit_way !== want.way)
						log_failure($sformatf("hit_way: expected %0d, got %0d",
							want.way, hit_way));
				end
			end
			if (start && !busy) begin
				want = learn_id(func_t'(func), type_id, type_hash);
				if (pin_valid)
					want = pin_verdict;
				pending_verdicts.push_back(want);
			end
			quiet_cycles <= moved ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// Reset, directed table, then random phases with varying sender gaps
	initial begin : stimulus
		int                counted;
		int                kind;
		func_t             op;
		logic [ID_W-1:0]   id;
		logic [HASH_W-1:0] hash;
		foreach (seen_rows[s, w]) seen_rows[s][w] = '0;
		foreach (id_pool[i]) id_pool[i] = {$urandom(), $urandom()} | ID_W'(1);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			issue_item(directed_rows[i].op, directed_rows[i].id, directed_rows[i].hash,
				directed_rows[i].pinned, '{emit: directed_rows[i].emit,
				way: directed_rows[i].way});

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			idle_pct = PHASE_IDLE[phase];
			counted  = 0;
			while (counted < RANDOM_ITEMS / NUM_PHASES) begin
				kind = $urandom_range(99);
				op   = FUNC_LOOKUP;
				id   = {$urandom(), $urandom()};
				hash = $urandom();
				if (kind < 3) begin
					op = FUNC_CLEAR;
				end else if (kind < 8) begin
					id = '0;
				end else if (kind >= 20) begin
					// small id pool over a few hot sets keeps the sets busy with hits
					id = id_pool[$urandom_range(ID_POOL_SIZE - 1)];
					if ($urandom_range(9) < 8)
						hash[SET_W-1:0] = SET_W'($urandom_range(3));
				end
				issue_item(op, id, hash, 1'b0, '0);
				if (op == FUNC_CLEAR || id != '0)
					counted++;
			end
			// hold off until the filter has drained
			if (phase == PRESSURE_PHASE) begin
				start <= 1'b0;
				do @(posedge clk); while (pending_verdicts.size() != 0);
			end
		end

		start <= 1'b0;
		do @(posedge clk); while (pending_verdicts.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

[filelist.f]
sv/salsf_pkg.sv
sv/salsf_ctrl.sv
sv/salsf_dp.sv
sv/set_assoc_lru_seen_filter.sv
bench/set_assoc_lru_seen_filter_test.sv
